/* rtl/cbk_pkg.sv */
package cbk_pkg;

    // Field and datapath widths
    localparam int FieldW  = 48;
    localparam int CfgW    = 32;
    localparam int BasisW  = 34;
    localparam int DotW    = 84;
    localparam int RootW   = 49;
    localparam int SqInW   = 97;
    localparam int NumW    = 116;
    localparam int DenW    = 84;
    localparam int DotNum  = 6;

    // Configuration register indexes
    localparam logic [2:0] REG_LOS_X   = 3'd0;
    localparam logic [2:0] REG_LOS_Y   = 3'd1;
    localparam logic [2:0] REG_LOS_Z   = 3'd2;
    localparam logic [2:0] REG_TAN_A_X = 3'd3;
    localparam logic [2:0] REG_TAN_A_Y = 3'd4;
    localparam logic [2:0] REG_TAN_A_Z = 3'd5;

    // Reset values of the basis, Q2.30
    localparam logic [CfgW-1:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [CfgW-1:0] ZERO_Q30 = 32'h0000_0000;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_POS = 2'd1;
    localparam logic [1:0] ST_ZERO_LOS = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // Dot product slots: position or velocity against a, b, n0
    localparam int DOT_PA = 0;
    localparam int DOT_PB = 1;
    localparam int DOT_PN = 2;
    localparam int DOT_VA = 3;
    localparam int DOT_VB = 4;
    localparam int DOT_VN = 5;

    typedef struct packed {
        logic [2:0][CfgW-1:0] los;
        logic [2:0][CfgW-1:0] tan_a;
    } basis_t;

    typedef struct packed {
        logic                         pos_zero;
        logic [DotNum-1:0][DotW-1:0]  dot;
    } dots_t;

    typedef struct packed {
        logic [RootW-1:0] nrm;
        dots_t            dots;
    } item_t;

endpackage

/* rtl/cbk_sqrt.sv */
module cbk_sqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [cbk_pkg::SqInW-1:0] in_x,
    input  cbk_pkg::dots_t            in_pay,
    output logic                      out_valid,
    output logic [cbk_pkg::RootW-1:0] out_root,
    output cbk_pkg::dots_t            out_pay
);

    localparam int Steps = cbk_pkg::RootW;
    localparam int RemW  = 2 * cbk_pkg::RootW;

    logic                      vld_reg  [0:Steps-1];
    logic [RemW-1:0]           rem_reg  [0:Steps-1];
    logic [cbk_pkg::RootW-1:0] root_reg [0:Steps-1];
    cbk_pkg::dots_t            pay_reg  [0:Steps-1];

    // One root bit per stage, most significant first
    for (genvar k = 0; k < Steps; k++) begin : g_stage
        localparam int B = Steps - 1 - k;
        logic                      vld_in;
        logic [RemW-1:0]           rem_in;
        logic [RemW-1:0]           trial;
        logic [cbk_pkg::RootW-1:0] root_in;
        cbk_pkg::dots_t            pay_in;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = {{(RemW-cbk_pkg::SqInW){1'b0}}, in_x};
            assign root_in = '0;
            assign pay_in  = in_pay;
        end
        else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign pay_in  = pay_reg[k-1];
        end

        // trial = (r + 2^B)^2 - r^2
        assign trial = ({{(RemW-cbk_pkg::RootW){1'b0}}, root_in} << (B + 1))
                     | ({{(RemW-1){1'b0}}, 1'b1} << (2 * B));

        // Advance the valid flag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_in;
        end

        // Keep the bit where the trial fits in the remainder
        always_ff @(posedge clk)
        begin
            pay_reg[k] <= pay_in;
            if (trial <= rem_in)
            begin
                rem_reg[k]  <= rem_in - trial;
                root_reg[k] <= root_in | ({{(cbk_pkg::RootW-1){1'b0}}, 1'b1} << B);
            end
            else
            begin
                rem_reg[k]  <= rem_in;
                root_reg[k] <= root_in;
            end
        end
    end

    assign out_valid = vld_reg[Steps-1];
    assign out_root  = root_reg[Steps-1];
    assign out_pay   = pay_reg[Steps-1];

endmodule

/* rtl/cbk_front.sv */
module cbk_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [cbk_pkg::FieldW-1:0] pos_x,
    input  logic [cbk_pkg::FieldW-1:0] pos_y,
    input  logic [cbk_pkg::FieldW-1:0] pos_z,
    input  logic [cbk_pkg::FieldW-1:0] vel_x,
    input  logic [cbk_pkg::FieldW-1:0] vel_y,
    input  logic [cbk_pkg::FieldW-1:0] vel_z,
    input  cbk_pkg::basis_t            basis,
    output logic                       out_valid,
    output cbk_pkg::item_t             out_item
);

    localparam int FW = cbk_pkg::FieldW;
    localparam int DW = cbk_pkg::DotW;
    localparam int BW = cbk_pkg::BasisW;

    // b = n0 x a, registered from the basis
    logic signed [2*cbk_pkg::CfgW-1:0] bp_reg [0:5];
    logic        [2*cbk_pkg::CfgW-1:0] bdiff  [0:2];
    logic        [BW-1:0]              b_reg  [0:2];

    logic          v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic          zero1_reg, zero2_reg, zero3_reg, zero4_reg;
    logic [FW-1:0] p0_reg   [0:2];
    logic [FW-1:0] vel0_reg [0:2];
    logic [FW-1:0] p1_reg   [0:2];
    logic [FW-1:0] vel1_reg [0:2];
    logic [FW-1:0] mag1_reg [0:2];

    logic        [FW-1:0] xs [0:5][0:2];
    logic signed [BW-1:0] ys [0:5][0:2];

    logic signed [FW/2+BW-1:0] ph_reg [0:5][0:2];
    logic signed [FW/2+BW:0]   pl_reg [0:5][0:2];
    logic [FW-1:0]             hh_reg [0:2];
    logic [FW-1:0]             hl_reg [0:2];
    logic [FW-1:0]             ll_reg [0:2];

    logic [DW-1:0]             term_reg [0:5][0:2];
    logic [cbk_pkg::SqInW-1:0] sq_reg   [0:2];

    logic [cbk_pkg::DotNum-1:0][DW-1:0] dot4_reg;
    logic [cbk_pkg::SqInW-1:0]          r2_reg;

    cbk_pkg::dots_t            sq_pay_in;
    cbk_pkg::dots_t            sq_pay_out;
    logic [cbk_pkg::RootW-1:0] sq_root;

    // Form the cross product terms
    always_ff @(posedge clk)
    begin
        bp_reg[0] <= $signed(basis.los[1]) * $signed(basis.tan_a[2]);
        bp_reg[1] <= $signed(basis.los[2]) * $signed(basis.tan_a[1]);
        bp_reg[2] <= $signed(basis.los[2]) * $signed(basis.tan_a[0]);
        bp_reg[3] <= $signed(basis.los[0]) * $signed(basis.tan_a[2]);
        bp_reg[4] <= $signed(basis.los[0]) * $signed(basis.tan_a[1]);
        bp_reg[5] <= $signed(basis.los[1]) * $signed(basis.tan_a[0]);
    end

    always_comb
    begin
        bdiff[0] = bp_reg[0] - bp_reg[1];
        bdiff[1] = bp_reg[2] - bp_reg[3];
        bdiff[2] = bp_reg[4] - bp_reg[5];
    end

    // Drop 30 fraction bits, rounding toward minus infinity
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            b_reg[c] <= bdiff[c][63:30];
    end

    // Advance the valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= take;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p0_reg[0]   <= pos_x;
            p0_reg[1]   <= pos_y;
            p0_reg[2]   <= pos_z;
            vel0_reg[0] <= vel_x;
            vel0_reg[1] <= vel_y;
            vel0_reg[2] <= vel_z;
        end
    end

    // Take position magnitudes and flag a zero position
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            p1_reg[c]   <= p0_reg[c];
            vel1_reg[c] <= vel0_reg[c];
            mag1_reg[c] <= p0_reg[c][FW-1] ? (~p0_reg[c] + {{(FW-1){1'b0}}, 1'b1})
                                          : p0_reg[c];
        end
        zero1_reg <= (p0_reg[0] == '0) && (p0_reg[1] == '0) && (p0_reg[2] == '0);
    end

    // Select dot product operands
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            xs[cbk_pkg::DOT_PA][c] = p1_reg[c];
            xs[cbk_pkg::DOT_PB][c] = p1_reg[c];
            xs[cbk_pkg::DOT_PN][c] = p1_reg[c];
            xs[cbk_pkg::DOT_VA][c] = vel1_reg[c];
            xs[cbk_pkg::DOT_VB][c] = vel1_reg[c];
            xs[cbk_pkg::DOT_VN][c] = vel1_reg[c];
            ys[cbk_pkg::DOT_PA][c] = {{2{basis.tan_a[c][31]}}, basis.tan_a[c]};
            ys[cbk_pkg::DOT_PB][c] = b_reg[c];
            ys[cbk_pkg::DOT_PN][c] = {{2{basis.los[c][31]}}, basis.los[c]};
            ys[cbk_pkg::DOT_VA][c] = {{2{basis.tan_a[c][31]}}, basis.tan_a[c]};
            ys[cbk_pkg::DOT_VB][c] = b_reg[c];
            ys[cbk_pkg::DOT_VN][c] = {{2{basis.los[c][31]}}, basis.los[c]};
        end
    end

    // Partial products on 24-bit halves
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 6; d++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ph_reg[d][c] <= $signed(xs[d][c][FW-1:FW/2]) * ys[d][c];
                pl_reg[d][c] <= $signed({1'b0, xs[d][c][FW/2-1:0]}) * ys[d][c];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            hh_reg[c] <= mag1_reg[c][FW-1:FW/2] * mag1_reg[c][FW-1:FW/2];
            hl_reg[c] <= mag1_reg[c][FW-1:FW/2] * mag1_reg[c][FW/2-1:0];
            ll_reg[c] <= mag1_reg[c][FW/2-1:0] * mag1_reg[c][FW/2-1:0];
        end
        zero2_reg <= zero1_reg;
    end

    // Combine halves into full products
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 6; d++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                term_reg[d][c] <= ({{(DW-FW/2-BW){ph_reg[d][c][FW/2+BW-1]}}, ph_reg[d][c]}
                                   << (FW/2))
                                + {{(DW-FW/2-BW-1){pl_reg[d][c][FW/2+BW]}}, pl_reg[d][c]};
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c] <= ({{(cbk_pkg::SqInW-FW){1'b0}}, hh_reg[c]} << FW)
                       + ({{(cbk_pkg::SqInW-FW){1'b0}}, hl_reg[c]} << (FW/2 + 1))
                       + {{(cbk_pkg::SqInW-FW){1'b0}}, ll_reg[c]};
        end
        zero3_reg <= zero2_reg;
    end

    // Sum the three components
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 6; d++)
            dot4_reg[d] <= term_reg[d][0] + term_reg[d][1] + term_reg[d][2];
        r2_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        zero4_reg <= zero3_reg;
    end

    assign sq_pay_in.pos_zero = zero4_reg;
    assign sq_pay_in.dot      = dot4_reg;

    cbk_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_x      (r2_reg),
        .in_pay    (sq_pay_in),
        .out_valid (out_valid),
        .out_root  (sq_root),
        .out_pay   (sq_pay_out)
    );

    assign out_item.nrm  = sq_root;
    assign out_item.dots = sq_pay_out;

endmodule

/* rtl/cbk_queue.sv */
module cbk_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  cbk_pkg::item_t wr_item,
    output logic           full,
    output logic           rd_valid,
    output cbk_pkg::item_t rd_item,
    input  logic           rd_pop
);

    cbk_pkg::item_t slot_reg [0:1];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_wr, do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_pop && rd_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries until read
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

/* rtl/cbk_div.sv */
module cbk_div
(
    input  logic                       clk,
    input  logic [cbk_pkg::NumW-1:0]   in_num,
    input  logic [cbk_pkg::DenW-1:0]   in_den,
    input  logic                       in_neg,
    output logic [cbk_pkg::FieldW-1:0] out_q,
    output logic                       out_ovf,
    output logic                       out_neg
);

    localparam int QW    = cbk_pkg::FieldW;
    localparam int DW    = cbk_pkg::DenW;
    localparam int HiW   = cbk_pkg::NumW - QW;
    localparam int Steps = QW;

    logic [DW-1:0] rem_reg [0:Steps];
    logic [QW-1:0] low_reg [0:Steps];
    logic [QW-1:0] q_reg   [0:Steps];
    logic [DW-1:0] den_reg [0:Steps];
    logic          ovf_reg [0:Steps];
    logic          neg_reg [0:Steps];

    logic [DW:0] sh   [1:Steps];
    logic [DW:0] diff [1:Steps];
    logic        ge   [1:Steps];

    // Load: a quotient of 2^48 or more shows as the top bits reaching the divisor
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {{(DW-HiW){1'b0}}, in_num[cbk_pkg::NumW-1:QW]};
        low_reg[0] <= in_num[QW-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= in_den;
        ovf_reg[0] <= ({{(DW-HiW){1'b0}}, in_num[cbk_pkg::NumW-1:QW]} >= in_den);
        neg_reg[0] <= in_neg;
    end

    // Shift in one dividend bit and try the subtract
    always_comb
    begin
        for (int k = 1; k <= Steps; k++)
        begin
            sh[k]   = {rem_reg[k-1], low_reg[k-1][QW-1]};
            diff[k] = sh[k] - {1'b0, den_reg[k-1]};
            ge[k]   = (sh[k] >= {1'b0, den_reg[k-1]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= Steps; k++)
        begin
            rem_reg[k] <= ge[k] ? diff[k][DW-1:0] : sh[k][DW-1:0];
            low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
            q_reg[k]   <= {q_reg[k-1][QW-2:0], ge[k]};
            den_reg[k] <= den_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
        end
    end

    assign out_q   = q_reg[Steps];
    assign out_ovf = ovf_reg[Steps];
    assign out_neg = neg_reg[Steps];

endmodule

/* rtl/cbk_back.sv */
module cbk_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  cbk_pkg::item_t             in_item,
    output logic                       pop,
    output logic                       done,
    output logic [cbk_pkg::FieldW-1:0] tan_alpha,
    output logic [cbk_pkg::FieldW-1:0] tan_beta,
    output logic [cbk_pkg::FieldW-1:0] inv_range,
    output logic [cbk_pkg::FieldW-1:0] rate_a,
    output logic [cbk_pkg::FieldW-1:0] rate_b,
    output logic [cbk_pkg::FieldW-1:0] rate_los,
    output logic [1:0]                 status
);

    localparam int FW    = cbk_pkg::FieldW;
    localparam int NW    = cbk_pkg::NumW;
    localparam int DW    = cbk_pkg::DenW;
    localparam int Lat   = cbk_pkg::FieldW + 1;
    localparam int InvSh = 72;

    // Divider slots
    localparam int DV_ALPHA = 0;
    localparam int DV_BETA  = 1;
    localparam int DV_INV   = 2;
    localparam int DV_RA    = 3;
    localparam int DV_RB    = 4;
    localparam int DV_RN    = 5;

    localparam logic [FW-1:0] POS_LIM = {1'b0, {(FW-1){1'b1}}};
    localparam logic [FW-1:0] NEG_LIM = {1'b1, {(FW-1){1'b0}}};
    localparam logic [FW-1:0] U_MAX   = {FW{1'b1}};

    logic          b0_vld_reg;
    logic [NW-1:0] num_reg [0:5];
    logic [DW-1:0] den_reg [0:5];
    logic          neg_reg [0:5];
    logic          zpos_b0_reg, zlos_b0_reg;

    logic [DW-1:0] mag [0:5];
    logic          pn_neg;

    logic          vld_d_reg  [0:Lat-1];
    logic          zpos_d_reg [0:Lat-1];
    logic          zlos_d_reg [0:Lat-1];

    logic [FW-1:0] dq   [0:5];
    logic          dovf [0:5];
    logic          dneg [0:5];

    logic [FW-1:0] lim  [0:5];
    logic          sat  [0:5];
    logic [FW-1:0] smag [0:5];
    logic [FW-1:0] val  [0:5];
    logic          sat_rest, sat_tan;

    logic          done_reg;
    logic [FW-1:0] alpha_reg, beta_reg, inv_reg, ra_reg, rb_reg, rn_reg;
    logic [1:0]    status_reg;
    logic [FW-1:0] alpha_next, beta_next, inv_next, ra_next, rb_next, rn_next;
    logic [1:0]    status_next;

    // The back end never stalls, so drain the queue every cycle
    assign pop = in_valid;

    // Magnitudes of the dot products
    always_comb
    begin
        for (int d = 0; d < 6; d++)
            mag[d] = in_item.dots.dot[d][DW-1] ? (~in_item.dots.dot[d] + {{(DW-1){1'b0}}, 1'b1})
                                               : in_item.dots.dot[d];
        pn_neg = in_item.dots.dot[cbk_pkg::DOT_PN][DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b0_vld_reg <= 1'b0;
        else
            b0_vld_reg <= in_valid;
    end

    // Set up dividend, divisor and sign for each divider
    always_ff @(posedge clk)
    begin
        num_reg[DV_ALPHA] <= {mag[cbk_pkg::DOT_PA], 32'b0};
        den_reg[DV_ALPHA] <= mag[cbk_pkg::DOT_PN];
        neg_reg[DV_ALPHA] <= in_item.dots.dot[cbk_pkg::DOT_PA][DW-1] ^ pn_neg;
        num_reg[DV_BETA]  <= {mag[cbk_pkg::DOT_PB], 32'b0};
        den_reg[DV_BETA]  <= mag[cbk_pkg::DOT_PN];
        neg_reg[DV_BETA]  <= in_item.dots.dot[cbk_pkg::DOT_PB][DW-1] ^ pn_neg;
        num_reg[DV_INV]   <= {{(NW-1){1'b0}}, 1'b1} << InvSh;
        den_reg[DV_INV]   <= {{(DW-cbk_pkg::RootW){1'b0}}, in_item.nrm};
        neg_reg[DV_INV]   <= 1'b0;
        num_reg[DV_RA]    <= {{(NW-DW){1'b0}}, mag[cbk_pkg::DOT_VA]};
        den_reg[DV_RA]    <= {{(DW-cbk_pkg::RootW-6){1'b0}}, in_item.nrm, 6'b0};
        neg_reg[DV_RA]    <= in_item.dots.dot[cbk_pkg::DOT_VA][DW-1];
        num_reg[DV_RB]    <= {{(NW-DW){1'b0}}, mag[cbk_pkg::DOT_VB]};
        den_reg[DV_RB]    <= {{(DW-cbk_pkg::RootW-6){1'b0}}, in_item.nrm, 6'b0};
        neg_reg[DV_RB]    <= in_item.dots.dot[cbk_pkg::DOT_VB][DW-1];
        num_reg[DV_RN]    <= {{(NW-DW){1'b0}}, mag[cbk_pkg::DOT_VN]};
        den_reg[DV_RN]    <= {{(DW-cbk_pkg::RootW-6){1'b0}}, in_item.nrm, 6'b0};
        neg_reg[DV_RN]    <= in_item.dots.dot[cbk_pkg::DOT_VN][DW-1];
        zpos_b0_reg       <= in_item.dots.pos_zero;
        zlos_b0_reg       <= (in_item.dots.dot[cbk_pkg::DOT_PN] == '0);
    end

    for (genvar i = 0; i < 6; i++) begin : g_div
        cbk_div u_div
        (
            .clk     (clk),
            .in_num  (num_reg[i]),
            .in_den  (den_reg[i]),
            .in_neg  (neg_reg[i]),
            .out_q   (dq[i]),
            .out_ovf (dovf[i]),
            .out_neg (dneg[i])
        );
    end

    // Carry valid and special-case flags alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Lat; k++)
                vld_d_reg[k] <= 1'b0;
        end
        else
        begin
            vld_d_reg[0] <= b0_vld_reg;
            for (int k = 1; k < Lat; k++)
                vld_d_reg[k] <= vld_d_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        zpos_d_reg[0] <= zpos_b0_reg;
        zlos_d_reg[0] <= zlos_b0_reg;
        for (int k = 1; k < Lat; k++)
        begin
            zpos_d_reg[k] <= zpos_d_reg[k-1];
            zlos_d_reg[k] <= zlos_d_reg[k-1];
        end
    end

    // Clamp quotients to the field range and apply the sign
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            lim[i]  = dneg[i] ? NEG_LIM : POS_LIM;
            sat[i]  = dovf[i] || (dq[i] > lim[i]);
            smag[i] = sat[i] ? lim[i] : dq[i];
            val[i]  = dneg[i] ? (~smag[i] + {{(FW-1){1'b0}}, 1'b1}) : smag[i];
        end
        val[DV_INV] = dovf[DV_INV] ? U_MAX : dq[DV_INV];
        sat[DV_INV] = dovf[DV_INV];
        sat_rest = sat[DV_INV] || sat[DV_RA] || sat[DV_RB] || sat[DV_RN];
        sat_tan  = sat[DV_ALPHA] || sat[DV_BETA];
    end

    // Pick status and zero out fields for the special cases
    always_comb
    begin
        alpha_next  = val[DV_ALPHA];
        beta_next   = val[DV_BETA];
        inv_next    = val[DV_INV];
        ra_next     = val[DV_RA];
        rb_next     = val[DV_RB];
        rn_next     = val[DV_RN];
        status_next = cbk_pkg::ST_OK;
        if (zpos_d_reg[Lat-1])
        begin
            alpha_next  = '0;
            beta_next   = '0;
            inv_next    = '0;
            ra_next     = '0;
            rb_next     = '0;
            rn_next     = '0;
            status_next = cbk_pkg::ST_ZERO_POS;
        end
        else if (zlos_d_reg[Lat-1])
        begin
            alpha_next  = '0;
            beta_next   = '0;
            status_next = cbk_pkg::ST_ZERO_LOS;
        end
        else if (sat_rest || sat_tan)
        begin
            status_next = cbk_pkg::ST_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_d_reg[Lat-1];
    end

    // Hold the result for its transfer cycle
    always_ff @(posedge clk)
    begin
        alpha_reg  <= alpha_next;
        beta_reg   <= beta_next;
        inv_reg    <= inv_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rn_reg     <= rn_next;
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign tan_alpha = alpha_reg;
    assign tan_beta  = beta_reg;
    assign inv_range = inv_reg;
    assign rate_a    = ra_reg;
    assign rate_b    = rb_reg;
    assign rate_los  = rn_reg;
    assign status    = status_reg;

endmodule

/* rtl/cartesian_to_bk_state.sv */
// Converts one position and velocity per cycle into tangent-plane parameters.
// An item is taken at each rising edge with start high and busy low; busy stays
// low in normal use, so a new item may enter every cycle. Each result shows on
// the result ports for one cycle with done high, in order; the receiver cannot
// stall it. Its path runs through five capture, multiply and sum stages, the
// 49-stage square root (one root bit per stage), the queue, the divider setup
// register, the 49-stage dividers (a load stage, then one quotient bit per
// stage), and the output register. The user must see that basis registers are
// written through the cfg port only while no item is in flight; the block does
// not enforce this. b is formed as n0 x a through registered products.
module cartesian_to_bk_state
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cbk_pkg::FieldW-1:0] pos_x,
    input  logic [cbk_pkg::FieldW-1:0] pos_y,
    input  logic [cbk_pkg::FieldW-1:0] pos_z,
    input  logic [cbk_pkg::FieldW-1:0] vel_x,
    input  logic [cbk_pkg::FieldW-1:0] vel_y,
    input  logic [cbk_pkg::FieldW-1:0] vel_z,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [cbk_pkg::CfgW-1:0]   cfg_data,
    output logic                       done,
    output logic [cbk_pkg::FieldW-1:0] tan_alpha,
    output logic [cbk_pkg::FieldW-1:0] tan_beta,
    output logic [cbk_pkg::FieldW-1:0] inv_range,
    output logic [cbk_pkg::FieldW-1:0] rate_a,
    output logic [cbk_pkg::FieldW-1:0] rate_b,
    output logic [cbk_pkg::FieldW-1:0] rate_los,
    output logic [1:0]                 status
);

    cbk_pkg::basis_t basis_reg;
    cbk_pkg::item_t  fe_item, q_item;
    logic            fe_valid, q_full, q_valid, q_pop;
    logic            take;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign take      = start && !busy;

    // Basis register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_reg.los[0]   <= cbk_pkg::ONE_Q30;
            basis_reg.los[1]   <= cbk_pkg::ZERO_Q30;
            basis_reg.los[2]   <= cbk_pkg::ZERO_Q30;
            basis_reg.tan_a[0] <= cbk_pkg::ZERO_Q30;
            basis_reg.tan_a[1] <= cbk_pkg::ONE_Q30;
            basis_reg.tan_a[2] <= cbk_pkg::ZERO_Q30;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cbk_pkg::REG_LOS_X:   basis_reg.los[0]   <= cfg_data;
                cbk_pkg::REG_LOS_Y:   basis_reg.los[1]   <= cfg_data;
                cbk_pkg::REG_LOS_Z:   basis_reg.los[2]   <= cfg_data;
                cbk_pkg::REG_TAN_A_X: basis_reg.tan_a[0] <= cfg_data;
                cbk_pkg::REG_TAN_A_Y: basis_reg.tan_a[1] <= cfg_data;
                cbk_pkg::REG_TAN_A_Z: basis_reg.tan_a[2] <= cfg_data;
                default:              basis_reg          <= basis_reg;
            endcase
        end
    end

    cbk_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .basis     (basis_reg),
        .out_valid (fe_valid),
        .out_item  (fe_item)
    );

    cbk_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_item  (fe_item),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .rd_pop   (q_pop)
    );

    cbk_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .pop       (q_pop),
        .done      (done),
        .tan_alpha (tan_alpha),
        .tan_beta  (tan_beta),
        .inv_range (inv_range),
        .rate_a    (rate_a),
        .rate_b    (rate_b),
        .rate_los  (rate_los),
        .status    (status)
    );

endmodule

/* rtl/cbk_checker.sv */
module cbk_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [cbk_pkg::FieldW-1:0] tan_alpha,
    input logic [cbk_pkg::FieldW-1:0] tan_beta,
    input logic [cbk_pkg::FieldW-1:0] inv_range,
    input logic [cbk_pkg::FieldW-1:0] rate_a,
    input logic [cbk_pkg::FieldW-1:0] rate_b,
    input logic [cbk_pkg::FieldW-1:0] rate_los,
    input logic [1:0]                 status
);

    logic [7:0] outstanding_reg;

    // Track items taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= 8'd0;
        else
            outstanding_reg <= outstanding_reg + {7'd0, start && !busy} - {7'd0, done};
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (outstanding_reg != 8'd0))
        else $error("result transfer with no item in flight");

    a_zero_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cbk_pkg::ST_ZERO_POS) |->
        (tan_alpha == '0 && tan_beta == '0 && inv_range == '0 &&
         rate_a == '0 && rate_b == '0 && rate_los == '0))
        else $error("zero position result carries nonzero fields");

    a_zero_los_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cbk_pkg::ST_ZERO_LOS) |-> (tan_alpha == '0 && tan_beta == '0))
        else $error("zero line-of-sight result carries nonzero gnomonic coordinates");

    a_ok_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cbk_pkg::ST_OK) |-> (inv_range != '0))
        else $error("valid result with zero inverse range");

endmodule

bind cartesian_to_bk_state cbk_checker u_cbk_checker (.*);
